// File: rtl/core/tlik_pkg.sv
package tlik_pkg;

   // number format
   localparam int FRAC     = 13;   // fraction bits of angles
   localparam int ITER     = 16;   // CORDIC micro-rotations
   localparam int XW       = 19;   // foot coordinate width
   localparam int LW       = 18;   // link length width
   localparam int AW       = 17;   // angle width
   localparam int SDW      = 2;    // leg side width
   localparam int STW      = 2;    // status width

   // configuration port
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = LW;
   localparam logic [CSR_IW-1:0] CSR_LONG_LEN  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_SHORT_LEN = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_ANGLE_HI  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_ANGLE_LO  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_LEG_SIDE  = 3'd4;

   localparam logic [LW-1:0]         RST_LONG_LEN  = 18'd200000;
   localparam logic [LW-1:0]         RST_SHORT_LEN = 18'd100000;
   localparam logic signed [AW-1:0]  RST_ANGLE_HI  = 17'sd25736;
   localparam logic signed [AW-1:0]  RST_ANGLE_LO  = -17'sd25736;
   localparam logic [SDW-1:0]        RST_LEG_SIDE  = 2'd0;

   localparam logic [SDW-1:0] SIDE_LEFT  = 2'd0;
   localparam logic [SDW-1:0] SIDE_RIGHT = 2'd1;

   // status codes
   localparam logic [STW-1:0] ST_UNREACHABLE = 2'd0;
   localparam logic [STW-1:0] ST_OK          = 2'd1;
   localparam logic [STW-1:0] ST_CLAMPED     = 2'd2;
   localparam logic [STW-1:0] ST_BAD_SIDE    = 2'd3;

   // datapath widths
   localparam int D2W      = 2 * XW;
   localparam int SUMW     = LW + 1;
   localparam int SUM2W    = 2 * SUMW;
   localparam int SQW      = 2 * LW;
   localparam int NUMW     = D2W + 2;
   localparam int D_SHIFT  = 16;
   localparam int R1IN     = D2W + D_SHIFT;
   localparam int R1W      = R1IN / 2;
   localparam int DENW     = LW + R1W + 1;
   localparam int M_SHIFT  = 8;
   localparam int MAGW     = NUMW + M_SHIFT;
   localparam int AQW      = FRAC + 2;
   localparam int R2IN     = 2 * FRAC + 2;
   localparam int R2W      = FRAC + 1;
   localparam int CIW      = (AQW > XW) ? AQW : XW;
   localparam int PRESHIFT = 24;
   localparam int CW       = CIW + PRESHIFT + 3;
   localparam int ZW       = 34;
   localparam int SZW      = ZW + 2;
   localparam int QFW      = SZW - (30 - FRAC);

   // request queue
   localparam int QD       = 4;
   localparam int QAW      = $clog2(QD);
   localparam int QCW      = QAW + 1;

   // back end stage positions
   localparam int K1       = R1W;
   localparam int KD       = K1 + 2 + FRAC;
   localparam int K2       = KD + 2 + R2W;
   localparam int KC       = K2 + 1 + ITER;
   localparam int LN       = KC + 3;
   localparam int BLAT     = KC + 3;
   localparam int TLAT     = KC + 6;

   localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;

   typedef struct packed {
      logic [LW-1:0]         long_len;
      logic [LW-1:0]         short_len;
      logic signed [AW-1:0]  angle_hi;
      logic signed [AW-1:0]  angle_lo;
      logic [SDW-1:0]        side;
   } cfg_type;

   typedef struct packed {
      logic [STW-1:0]          cls;
      logic signed [XW-1:0]    x;
      logic signed [XW-1:0]    y;
      logic [D2W-1:0]          d2;
      logic signed [NUMW-1:0]  num;
   } item_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 34'sh3243F6A8;
         1:  v = 34'sh1DAC6705;
         2:  v = 34'sh0FADBAFC;
         3:  v = 34'sh07F56EA6;
         4:  v = 34'sh03FEAB76;
         5:  v = 34'sh01FFD55B;
         6:  v = 34'sh00FFFAAA;
         7:  v = 34'sh007FFF55;
         8:  v = 34'sh003FFFEA;
         9:  v = 34'sh001FFFFD;
         10: v = 34'sh000FFFFF;
         11: v = 34'sh0007FFFF;
         12: v = 34'sh0003FFFF;
         13: v = 34'sh0001FFFF;
         14: v = 34'sh0000FFFF;
         15: v = 34'sh00007FFF;
         16: v = 34'sh00003FFF;
         17: v = 34'sh00001FFF;
         18: v = 34'sh00000FFF;
         19: v = 34'sh000007FF;
         20: v = 34'sh000003FF;
         21: v = 34'sh000001FF;
         22: v = 34'sh000000FF;
         23: v = 34'sh0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/tlik_front.sv
module tlik_front
   import tlik_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [XW-1:0] foot_x,
   input  logic signed [XW-1:0] foot_y,
   input  cfg_type              cfg,
   input  logic [QCW-1:0]       q_level,
   output logic                 busy,
   output logic                 out_vld,
   output item_type             out_item
);

   logic                 f1v_ff;
   logic                 f1v_in;
   logic signed [XW-1:0] f1x_ff, f1y_ff;
   logic [D2W-1:0]       xx_ff, yy_ff;
   logic [SUM2W-1:0]     sum2_ff;
   logic [SQW-1:0]       diff2_ff, ss_ff, ll_ff;

   logic signed [D2W-1:0] pxx, pyy;
   logic [SUMW-1:0]       sum;
   logic [LW-1:0]         diff;

   logic                  f2v_ff;
   item_type              f2_ff;
   item_type              f2_in;
   logic [D2W-1:0]        d2;
   logic                  unreach;
   logic [QCW:0]          occ;

   // requests in flight plus queued must leave room for one more
   assign occ  = {1'b0, q_level} + (QCW+1)'(f1v_ff) + (QCW+1)'(f2v_ff);
   assign busy = occ >= (QCW+1)'(QD);

   assign f1v_in = start && !busy;
   assign pxx    = foot_x * foot_x;
   assign pyy    = foot_y * foot_y;
   assign sum    = SUMW'(cfg.long_len) + SUMW'(cfg.short_len);
   assign diff   = (cfg.long_len > cfg.short_len) ? cfg.long_len - cfg.short_len
                                                   : cfg.short_len - cfg.long_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1v_ff <= 1'b0;
      end else begin
         f1v_ff <= f1v_in;
      end
   end

   always_ff @(posedge clock) begin
      f1x_ff   <= foot_x;
      f1y_ff   <= foot_y;
      xx_ff    <= unsigned'(pxx);
      yy_ff    <= unsigned'(pyy);
      sum2_ff  <= sum * sum;
      diff2_ff <= diff * diff;
      ss_ff    <= cfg.short_len * cfg.short_len;
      ll_ff    <= cfg.long_len * cfg.long_len;
   end

   assign d2      = xx_ff + yy_ff;
   assign unreach = (d2 > sum2_ff) || (d2 < D2W'(diff2_ff));

   always_comb begin
      f2_in.x   = f1x_ff;
      f2_in.y   = f1y_ff;
      f2_in.d2  = d2;
      f2_in.num = signed'(NUMW'(ss_ff)) + signed'(NUMW'(d2)) - signed'(NUMW'(ll_ff));
      if (unreach) begin
         f2_in.cls = ST_UNREACHABLE;
      end else if (cfg.side != SIDE_LEFT && cfg.side != SIDE_RIGHT) begin
         f2_in.cls = ST_BAD_SIDE;
      end else begin
         f2_in.cls = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2v_ff <= 1'b0;
      end else begin
         f2v_ff <= f1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      f2_ff <= f2_in;
   end

   assign out_vld  = f2v_ff;
   assign out_item = f2_ff;

endmodule

// File: rtl/core/tlik_queue.sv
module tlik_queue
   import tlik_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  item_type       push_item,
   input  logic           pop,
   output logic           pop_vld,
   output item_type       pop_item,
   output logic [QCW-1:0] level
);

   item_type         mem_ff [QD];
   logic [QAW-1:0]   wp_ff, rp_ff;
   logic [QCW-1:0]   level_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         level_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         case ({push, pop})
            2'b10:   level_ff <= level_ff + 1'b1;
            2'b01:   level_ff <= level_ff - 1'b1;
            default: level_ff <= level_ff;
         endcase
      end
   end

   assign pop_vld  = level_ff != '0;
   assign pop_item = mem_ff[rp_ff];
   assign level    = level_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> level_ff < QCW'(QD))
      else $error("request queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> level_ff != '0)
      else $error("request queue underflow");

endmodule

// File: rtl/core/tlik_cordic.sv
module tlik_cordic
   import tlik_pkg::*;
(
   input  logic                  clock,
   input  logic signed [CIW-1:0] xin,
   input  logic signed [CIW-1:0] yin,
   output logic signed [ZW-1:0]  zout
);

   logic signed [CW-1:0] cx_ff [0:ITER];
   logic signed [CW-1:0] cy_ff [0:ITER];
   logic signed [ZW-1:0] cz_ff [0:ITER];
   logic                 zf_ff [0:ITER];

   logic signed [CW-1:0] xs, ys;

   assign xs = CW'(xin) <<< PRESHIFT;
   assign ys = CW'(yin) <<< PRESHIFT;

   // quadrant pre-rotation into the right half plane
   always_ff @(posedge clock) begin
      zf_ff[0] <= (xin == '0) && (yin == '0);
      if (xs < 0) begin
         if (ys >= 0) begin
            cx_ff[0] <= ys;
            cy_ff[0] <= -xs;
            cz_ff[0] <= Q30_HALF_PI;
         end else begin
            cx_ff[0] <= -ys;
            cy_ff[0] <= xs;
            cz_ff[0] <= -Q30_HALF_PI;
         end
      end else begin
         cx_ff[0] <= xs;
         cy_ff[0] <= ys;
         cz_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      always_ff @(posedge clock) begin
         zf_ff[i+1] <= zf_ff[i];
         if (cy_ff[i] >= 0) begin
            cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
            cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
            cz_ff[i+1] <= cz_ff[i] + atan_q30(i);
         end else begin
            cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
            cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
            cz_ff[i+1] <= cz_ff[i] - atan_q30(i);
         end
      end
   end

   assign zout = zf_ff[ITER] ? '0 : cz_ff[ITER];

endmodule

// File: rtl/core/tlik_back.sv
module tlik_back
   import tlik_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  item_type             in_item,
   input  cfg_type              cfg,
   output logic                 out_vld,
   output logic [STW-1:0]       out_status,
   output logic signed [AW-1:0] out_inner,
   output logic signed [AW-1:0] out_outer
);

   typedef struct packed {
      logic [STW-1:0]       cls;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
   } ln_type;

   typedef struct packed {
      logic [R1IN-1:0] v;
      logic [R1W+1:0]  rem;
      logic [R1W-1:0]  root;
   } sq1_type;

   typedef struct packed {
      logic [R2IN-1:0]       v;
      logic [R2W+1:0]        rem;
      logic [R2W-1:0]        root;
      logic signed [AQW-1:0] a;
   } sq2_type;

   typedef struct packed {
      logic [MAGW-1:0] mag;
      logic [DENW-1:0] den;
      logic [FRAC-1:0] q;
      logic            neg;
      logic            sat;
      logic            zro;
   } dv_type;

   localparam logic signed [AQW-1:0] A_ONE = AQW'(1) <<< FRAC;
   localparam logic signed [AW-1:0]  A_MIN = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW-1:0]  A_MAX = {1'b0, {(AW-1){1'b1}}};

   function automatic sq1_type sq1_step(input sq1_type s);
      logic [R1W+1:0] r;
      logic [R1W+1:0] t;
      sq1_type        o;
      r      = {s.rem[R1W-1:0], s.v[R1IN-1 -: 2]};
      t      = {s.root, 2'b01};
      o.v    = s.v << 2;
      if (r >= t) begin
         o.rem  = r - t;
         o.root = {s.root[R1W-2:0], 1'b1};
      end else begin
         o.rem  = r;
         o.root = {s.root[R1W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic sq2_type sq2_step(input sq2_type s);
      logic [R2W+1:0] r;
      logic [R2W+1:0] t;
      sq2_type        o;
      r      = {s.rem[R2W-1:0], s.v[R2IN-1 -: 2]};
      t      = {s.root, 2'b01};
      o.v    = s.v << 2;
      o.a    = s.a;
      if (r >= t) begin
         o.rem  = r - t;
         o.root = {s.root[R2W-2:0], 1'b1};
      end else begin
         o.rem  = r;
         o.root = {s.root[R2W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic dv_type dv_step(input dv_type s);
      logic [MAGW-1:0] m2;
      dv_type          o;
      o  = s;
      m2 = {s.mag[MAGW-2:0], 1'b0};
      if (m2 >= MAGW'(s.den)) begin
         o.mag = m2 - MAGW'(s.den);
         o.q   = {s.q[FRAC-2:0], 1'b1};
      end else begin
         o.mag = m2;
         o.q   = {s.q[FRAC-2:0], 1'b0};
      end
      return o;
   endfunction

   // control line and carried payload
   logic   lv_ff [0:LN-1];
   ln_type lp_ff [0:LN-1];

   logic [D2W-1:0]         d2_ff;
   logic signed [NUMW-1:0] num_ff [0:K1];
   sq1_type                sq1_ff [1:R1W];
   sq1_type                sq1_init;

   logic [DENW-1:0]        den_ff;
   logic [MAGW-1:0]        mag_ff;
   logic                   neg_ff;
   logic [NUMW-1:0]        num_abs;

   dv_type                 dv_ff [0:FRAC];
   logic signed [AQW-1:0]  a_ff;
   logic signed [AQW-1:0]  a_in;
   logic [R2IN-1:0]        t_ff;
   logic signed [AQW-1:0]  ae_ff;
   logic signed [2*AQW-1:0] t_full;
   sq2_type                sq2_ff [1:R2W];
   sq2_type                sq2_init;

   logic signed [ZW-1:0]   acz, atz;
   logic signed [SZW-1:0]  s_in, s_ou, r_in, r_ou;
   logic signed [QFW-1:0]  hin_ff, hou_ff;

   logic signed [QFW-1:0]  hi, lo, ci, co;
   logic signed [AW-1:0]   ni, no;
   logic                   clamped;

   logic [STW-1:0]         st_ff;
   logic signed [AW-1:0]   oi_ff, oo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LN; k++) lv_ff[k] <= 1'b0;
      end else begin
         lv_ff[0] <= in_vld;
         for (int k = 1; k < LN; k++) lv_ff[k] <= lv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      lp_ff[0].cls <= in_item.cls;
      lp_ff[0].x   <= in_item.x;
      lp_ff[0].y   <= in_item.y;
      for (int k = 1; k < LN; k++) lp_ff[k] <= lp_ff[k-1];
      d2_ff     <= in_item.d2;
      num_ff[0] <= in_item.num;
      for (int k = 1; k <= K1; k++) num_ff[k] <= num_ff[k-1];
   end

   // distance root, one result bit per stage
   assign sq1_init = '{v: {d2_ff, {D_SHIFT{1'b0}}}, rem: '0, root: '0};

   always_ff @(posedge clock) begin
      sq1_ff[1] <= sq1_step(sq1_init);
      for (int k = 2; k <= R1W; k++) sq1_ff[k] <= sq1_step(sq1_ff[k-1]);
   end

   assign num_abs = (num_ff[K1] < 0) ? unsigned'(-num_ff[K1]) : unsigned'(num_ff[K1]);

   always_ff @(posedge clock) begin
      den_ff <= (DENW'(cfg.short_len) * DENW'(sq1_ff[R1W].root)) << 1;
      mag_ff <= {num_abs, {M_SHIFT{1'b0}}};
      neg_ff <= num_ff[K1] < 0;
   end

   // ratio: saturate at one, else restoring divide one bit per stage
   always_ff @(posedge clock) begin
      dv_ff[0].mag <= mag_ff;
      dv_ff[0].den <= den_ff;
      dv_ff[0].q   <= '0;
      dv_ff[0].neg <= neg_ff;
      dv_ff[0].zro <= den_ff == '0;
      dv_ff[0].sat <= (den_ff == '0) || (mag_ff >= MAGW'(den_ff));
      for (int k = 1; k <= FRAC; k++) dv_ff[k] <= dv_step(dv_ff[k-1]);
   end

   always_comb begin
      if (dv_ff[FRAC].zro) begin
         a_in = A_ONE;
      end else if (dv_ff[FRAC].sat) begin
         a_in = dv_ff[FRAC].neg ? -A_ONE : A_ONE;
      end else begin
         a_in = dv_ff[FRAC].neg ? -signed'({2'b00, dv_ff[FRAC].q})
                                :  signed'({2'b00, dv_ff[FRAC].q});
      end
   end

   assign t_full = ((2*AQW)'(1) <<< (2*FRAC)) - a_ff * a_ff;

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      t_ff  <= t_full[R2IN-1:0];
      ae_ff <= a_ff;
   end

   // sine term root
   assign sq2_init = '{v: t_ff, rem: '0, root: '0, a: ae_ff};

   always_ff @(posedge clock) begin
      sq2_ff[1] <= sq2_step(sq2_init);
      for (int k = 2; k <= R2W; k++) sq2_ff[k] <= sq2_step(sq2_ff[k-1]);
   end

   tlik_cordic u_acos (
      .clock (clock),
      .xin   (CIW'(sq2_ff[R2W].a)),
      .yin   (signed'(CIW'(sq2_ff[R2W].root))),
      .zout  (acz)
   );

   tlik_cordic u_atan (
      .clock (clock),
      .xin   (CIW'(lp_ff[K2].x)),
      .yin   (CIW'(lp_ff[K2].y)),
      .zout  (atz)
   );

   assign s_in = SZW'(acz) + SZW'(atz);
   assign s_ou = SZW'(acz) - SZW'(atz) - SZW'(Q30_PI);
   assign r_in = (s_in + (SZW'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
   assign r_ou = (s_ou + (SZW'(1) <<< (29 - FRAC))) >>> (30 - FRAC);

   always_ff @(posedge clock) begin
      hin_ff <= QFW'(r_in);
      hou_ff <= QFW'(r_ou);
   end

   // high limit first, so a crossed pair ends at the low limit
   assign hi = QFW'(cfg.angle_hi);
   assign lo = QFW'(cfg.angle_lo);

   always_comb begin
      ci = (hin_ff > hi) ? hi : hin_ff;
      ci = (ci < lo) ? lo : ci;
      co = (hou_ff > hi) ? hi : hou_ff;
      co = (co < lo) ? lo : co;
      clamped = (hin_ff > hi) || (hin_ff < lo) || (hou_ff > hi) || (hou_ff < lo);
      ni = (AW'(ci) == A_MIN) ? A_MAX : -AW'(ci);
      no = (AW'(co) == A_MIN) ? A_MAX : -AW'(co);
   end

   always_ff @(posedge clock) begin
      if (lp_ff[KC+1].cls != ST_OK) begin
         st_ff <= lp_ff[KC+1].cls;
         oi_ff <= '0;
         oo_ff <= '0;
      end else begin
         st_ff <= clamped ? ST_CLAMPED : ST_OK;
         oi_ff <= (cfg.side == SIDE_RIGHT) ? ni : AW'(ci);
         oo_ff <= (cfg.side == SIDE_RIGHT) ? no : AW'(co);
      end
   end

   assign out_vld    = lv_ff[LN-1];
   assign out_status = st_ff;
   assign out_inner  = oi_ff;
   assign out_outer  = oo_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      in_vld |-> ##BLAT out_vld)
      else $error("back end latency mismatch");

endmodule

// File: rtl/core/two_link_leg_inverse_kinematics.sv
// Pipeline from the accepting edge to the rsp_strobe cycle:
// 2 front stages, queue, 27 distance-root stages, 13 divide stages,
// 14 sine-root stages, 17 CORDIC stages, rounding, limit and output stages.
// Throughput: one request per clock unless busy; the back end never holds the queue.
// Synchronous reset clears the pipeline, the queue and loads default config.
// Results are presented for one cycle; the receiver cannot stall.
module two_link_leg_inverse_kinematics
   import tlik_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [XW-1:0]  req_foot_x,
   input  logic signed [XW-1:0]  req_foot_y,
   output logic                  rsp_strobe,
   output logic [STW-1:0]        rsp_status,
   output logic signed [AW-1:0]  rsp_inner_angle_cmd,
   output logic signed [AW-1:0]  rsp_outer_angle_cmd,
   input  logic                  csr_we,
   input  logic [CSR_IW-1:0]     csr_index,
   input  logic [CSR_DW-1:0]     csr_wdata
);

   cfg_type        cfg_ff;
   logic           f_vld;
   item_type       f_item;
   logic           q_vld;
   item_type       q_item;
   logic [QCW-1:0] q_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_len  <= RST_LONG_LEN;
         cfg_ff.short_len <= RST_SHORT_LEN;
         cfg_ff.angle_hi  <= RST_ANGLE_HI;
         cfg_ff.angle_lo  <= RST_ANGLE_LO;
         cfg_ff.side      <= RST_LEG_SIDE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_LEN:  cfg_ff.long_len  <= csr_wdata[LW-1:0];
            CSR_SHORT_LEN: cfg_ff.short_len <= csr_wdata[LW-1:0];
            CSR_ANGLE_HI:  cfg_ff.angle_hi  <= signed'(csr_wdata[AW-1:0]);
            CSR_ANGLE_LO:  cfg_ff.angle_lo  <= signed'(csr_wdata[AW-1:0]);
            CSR_LEG_SIDE:  cfg_ff.side      <= csr_wdata[SDW-1:0];
            default:       cfg_ff           <= cfg_ff;
         endcase
      end
   end

   tlik_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .foot_x   (req_foot_x),
      .foot_y   (req_foot_y),
      .cfg      (cfg_ff),
      .q_level  (q_level),
      .busy     (busy),
      .out_vld  (f_vld),
      .out_item (f_item)
   );

   tlik_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_vld),
      .push_item (f_item),
      .pop       (q_vld),
      .pop_vld   (q_vld),
      .pop_item  (q_item),
      .level     (q_level)
   );

   tlik_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (q_vld),
      .in_item    (q_item),
      .cfg        (cfg_ff),
      .out_vld    (rsp_strobe),
      .out_status (rsp_status),
      .out_inner  (rsp_inner_angle_cmd),
      .out_outer  (rsp_outer_angle_cmd)
   );

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##TLAT rsp_strobe)
      else $error("request did not produce a strobe on time");

endmodule

// File: dv/two_link_leg_inverse_kinematics_tb.sv
module two_link_leg_inverse_kinematics_tb;
   import tlik_pkg::*;

   typedef struct {
      logic [STW-1:0]         status;
      logic signed [AW-1:0]   inner;
      logic signed [AW-1:0]   outer;
   } joint_cmd_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;

   localparam longint ATAN_TBL [0:23] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic signed [XW-1:0]  req_foot_x;
   logic signed [XW-1:0]  req_foot_y;
   logic                  rsp_strobe;
   logic [STW-1:0]        rsp_status;
   logic signed [AW-1:0]  rsp_inner_angle_cmd;
   logic signed [AW-1:0]  rsp_outer_angle_cmd;
   logic                  csr_we;
   logic [CSR_IW-1:0]     csr_index;
   logic [CSR_DW-1:0]     csr_wdata;

   // shadow of the block's registers
   longint                long_len;
   longint                short_len;
   logic signed [AW-1:0]  angle_hi;
   logic signed [AW-1:0]  angle_lo;
   logic [SDW-1:0]        side;

   joint_cmd_type         pending_cmds[$];
   int                    errors = 0;
   int                    stall_cycles = 0;
   bit                    allow_gaps;

   two_link_leg_inverse_kinematics i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_foot_x          (req_foot_x),
      .req_foot_y          (req_foot_y),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_inner_angle_cmd (rsp_inner_angle_cmd),
      .rsp_outer_angle_cmd (rsp_outer_angle_cmd),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // vectoring CORDIC, angle in Q30
   function automatic longint atan2_q30(input longint y, input longint x);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * (64'sd1 <<< PRESHIFT);
      y = y * (64'sd1 <<< PRESHIFT);
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = Q30_HALF_PI;
         end else begin
            x = -y;
            y = t;
            z = -Q30_HALF_PI;
         end
      end
      for (int i = 0; i < ITER && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TBL[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TBL[i];
         end
      end
      return z;
   endfunction

   function automatic longint q30_round(input longint z);
      return (z + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
   endfunction

   function automatic joint_cmd_type solve_leg(input longint x, input longint y);
      joint_cmd_type    cmd;
      longint           one;
      longint           d2;
      longint           sum;
      longint           diff;
      longint           num;
      longint           a;
      longint           acz;
      longint           atz;
      longint           inner;
      longint           outer;
      longint           hi;
      longint           lo;
      longint unsigned  den;
      longint unsigned  mag;
      longint unsigned  q;
      bit               clamped;
      one = 64'sd1 <<< FRAC;
      cmd.status = ST_UNREACHABLE;
      cmd.inner = '0;
      cmd.outer = '0;
      d2 = x * x + y * y;
      sum = long_len + short_len;
      diff = (long_len > short_len) ? long_len - short_len : short_len - long_len;
      if (d2 > sum * sum || d2 < diff * diff) return cmd;
      if (side != SIDE_LEFT && side != SIDE_RIGHT) begin
         cmd.status = ST_BAD_SIDE;
         return cmd;
      end
      num = short_len * short_len + d2 - long_len * long_len;
      den = 2 * short_len * int_sqrt(d2 << 16);
      mag = (num < 0 ? -num : num) << 8;
      if (den == 0) begin
         a = one;   // degenerate triangle
      end else if (mag >= den) begin
         a = (num < 0) ? -one : one;
      end else begin
         q = 0;
         for (int i = 0; i < FRAC; i++) begin
            mag = mag << 1;
            q = q << 1;
            if (mag >= den) begin
               mag = mag - den;
               q = q | 1;
            end
         end
         a = (num < 0) ? -longint'(q) : longint'(q);
      end
      acz = atan2_q30(longint'(int_sqrt(one * one - a * a)), a);
      atz = atan2_q30(y, x);
      inner = q30_round(acz + atz);
      outer = q30_round(acz - atz - Q30_PI);
      hi = angle_hi;
      lo = angle_lo;
      clamped = inner > hi || inner < lo || outer > hi || outer < lo;
      // high limit first, so crossed limits end at the low one
      if (inner > hi) inner = hi;
      if (inner < lo) inner = lo;
      if (outer > hi) outer = hi;
      if (outer < lo) outer = lo;
      if (side == SIDE_RIGHT) begin
         inner = -inner;
         outer = -outer;
         if (inner > 65535) inner = 65535;
         if (outer > 65535) outer = 65535;
      end
      cmd.status = clamped ? ST_CLAMPED : ST_OK;
      cmd.inner = inner[AW-1:0];
      cmd.outer = outer[AW-1:0];
      return cmd;
   endfunction

   // leaves start high so back-to-back requests stay gapless
   task automatic send_target(input longint x, input longint y);
      start <= 1'b1;
      req_foot_x <= x[XW-1:0];
      req_foot_y <= y[XW-1:0];
      do @(posedge clock); while (busy);
      pending_cmds.push_back(solve_leg(x, y));
   endtask

   task automatic maybe_gap();
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input longint value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DW-1:0];
      @(posedge clock);
      case (idx)
         CSR_LONG_LEN:  long_len = value & 64'h3FFFF;
         CSR_SHORT_LEN: short_len = value & 64'h3FFFF;
         CSR_ANGLE_HI:  angle_hi = value[AW-1:0];
         CSR_ANGLE_LO:  angle_lo = value[AW-1:0];
         CSR_LEG_SIDE:  side = value[SDW-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input longint l, input longint s, input longint hi,
                             input longint lo, input longint sd);
      wait_idle();
      write_reg(CSR_LONG_LEN, l);
      write_reg(CSR_SHORT_LEN, s);
      write_reg(CSR_ANGLE_HI, hi);
      write_reg(CSR_ANGLE_LO, lo);
      write_reg(CSR_LEG_SIDE, sd);
      csr_we <= 1'b0;
   endtask

   task automatic test_default_targets();
      send_target(150000, 0);
      send_target(0, -150000);
      send_target(-150000, 0);
      send_target(100000, 0);           // exactly at inner reach
      send_target(99999, 0);            // just inside inner reach
      send_target(0, 0);
      send_target(262143, 0);
      send_target(-262144, -262144);
      send_target(212000, -212000);
      send_target(-100000, 150000);
   endtask

   task automatic test_leg_sides();
      set_config(200000, 100000, 25736, -25736, SIDE_RIGHT);
      send_target(150000, 20000);
      send_target(-120000, -90000);
      set_config(200000, 100000, 25736, -25736, 2);
      send_target(150000, 20000);
      send_target(0, 0);                // unreachable wins over bad side
      set_config(200000, 100000, 25736, -25736, 3);
      send_target(-150000, 0);
   endtask

   task automatic test_corner_configs();
      // equal links: origin is reachable with a zero denominator
      set_config(120000, 120000, 65535, -65536, SIDE_LEFT);
      send_target(0, 0);
      send_target(240000, 0);
      send_target(0, -239999);
      // crossed limits
      set_config(200000, 100000, -30000, 30000, SIDE_LEFT);
      send_target(150000, 0);
      // right-leg negation saturates
      set_config(200000, 100000, -65536, -65536, SIDE_RIGHT);
      send_target(150000, 10000);
      set_config(1, 1, 65535, 65535, SIDE_LEFT);
      send_target(1, 1);
      send_target(0, 2);
      set_config(262143, 262143, 0, 0, SIDE_RIGHT);
      send_target(-262144, 262143);
      send_target(262143, -262144);
   endtask

   task automatic test_random_targets(input int phases, input int per_phase);
      longint l;
      longint s;
      longint reach;
      longint x;
      longint y;
      for (int p = 0; p < phases; p++) begin
         if ($urandom_range(0, 3) == 0) begin
            l = $urandom_range(1, 262143);
            s = $urandom_range(1, 262143);
         end else begin
            l = $urandom_range(1000, 140000);
            s = $urandom_range(1000, 140000);
         end
         set_config(l, s, longint'($urandom_range(0, 131071)) - 65536,
                    longint'($urandom_range(0, 131071)) - 65536,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3)
                                                : $urandom_range(0, 1));
         reach = l + s;
         if (reach > 262143) reach = 262143;
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               x = longint'($urandom_range(0, 524287)) - 262144;
               y = longint'($urandom_range(0, 524287)) - 262144;
            end else begin
               x = longint'($urandom_range(0, 2 * reach)) - reach;
               y = longint'($urandom_range(0, 2 * reach)) - reach;
            end
            send_target(x, y);
            maybe_gap();
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      joint_cmd_type exp_cmd;
      if (!reset && rsp_strobe) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected response status=%0d inner=%0d outer=%0d", $time,
                     rsp_status, rsp_inner_angle_cmd, rsp_outer_angle_cmd);
            errors++;
         end else begin
            exp_cmd = pending_cmds.pop_front();
            if (rsp_status !== exp_cmd.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_cmd.status, rsp_status);
               errors++;
            end
            if (rsp_inner_angle_cmd !== exp_cmd.inner) begin
               $display("%0t: inner_angle_cmd expected %0d actual %0d", $time,
                        exp_cmd.inner, rsp_inner_angle_cmd);
               errors++;
            end
            if (rsp_outer_angle_cmd !== exp_cmd.outer) begin
               $display("%0t: outer_angle_cmd expected %0d actual %0d", $time,
                        exp_cmd.outer, rsp_outer_angle_cmd);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("two_link_leg_inverse_kinematics test failed");
            $finish;
         end
      end
   end

   initial begin
      allow_gaps = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_foot_x = '0;
      req_foot_y = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      long_len = RST_LONG_LEN;
      short_len = RST_SHORT_LEN;
      angle_hi = RST_ANGLE_HI;
      angle_lo = RST_ANGLE_LO;
      side = RST_LEG_SIDE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_targets();
      test_leg_sides();
      test_corner_configs();
      test_random_targets(8, 50);
      allow_gaps = 1'b0;
      test_random_targets(2, 50);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("two_link_leg_inverse_kinematics test passed");
      end else begin
         $display("two_link_leg_inverse_kinematics test failed");
      end
      $finish;
   end

endmodule
